// ===== src/pfc_pkg.sv =====
// Shared types, constants and register codes for the PID flow controller.
`default_nettype none

package pfc_pkg;

	localparam int FLOW_BITS_DEF      = 16;
	localparam int GAIN_FRAC_BITS_DEF = 12;
	localparam int GAIN_BITS          = 16;
	localparam int DRIVE_BITS         = 16;
	localparam int INTEGRAL_BITS      = 32;
	localparam int APB_ADDR_BITS      = 5;
	localparam int APB_DATA_BITS      = 32;
	localparam int REG_INDEX_BITS     = 3;

	localparam logic [GAIN_BITS-1:0] GAIN_P_RST         = 16'd3277;
	localparam logic [GAIN_BITS-1:0] GAIN_I_RST         = 16'd2048;
	localparam logic [GAIN_BITS-1:0] GAIN_D_RST         = 16'd82;
	localparam logic [GAIN_BITS-1:0] OUTPUT_FLOOR_RST   = 16'd0;
	localparam logic [GAIN_BITS-1:0] OUTPUT_CEILING_RST = 16'd100;

	typedef enum logic [REG_INDEX_BITS-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_OUTPUT_FLOOR   = 3'd3,
		REG_OUTPUT_CEILING = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		LIMIT_NONE = 2'd0,
		LIMIT_HIGH = 2'd1,
		LIMIT_LOW  = 2'd2
	} limit_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0] gain_p;
		logic [GAIN_BITS-1:0] gain_i;
		logic [GAIN_BITS-1:0] gain_d;
		logic [GAIN_BITS-1:0] output_floor;
		logic [GAIN_BITS-1:0] output_ceiling;
	} pfc_cfg_t;

endpackage

`default_nettype wire

// ===== src/pid_flow_controller.sv =====
// PID flow controller top level: register file, input stage, control step and result register.
`default_nettype none

// The controller takes one item per clock cycle while the result side does not stall. An
// accepted item is held in an input register; the control step is computed from it and
// loaded into the result register, which presents the result until it is taken.
// The integral and previous measurement are updated in the same cycle as the step that uses
// them, which is what lets consecutive items follow each other cycle by cycle. A stalled
// result holds in the output register while one further item waits in the input register.
// Gains and limits must be written through the APB port only while no item is in flight;
// the block itself does not enforce this.
module pid_flow_controller #(
	parameter int FLOW_BITS      = pfc_pkg::FLOW_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pfc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pfc_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [pfc_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [pfc_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [FLOW_BITS-1:0]              measured_flow,
	input  wire logic [FLOW_BITS-1:0]              target_flow,
	input  wire logic                              clear_history,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [pfc_pkg::DRIVE_BITS-1:0]    drive_value,
	output logic      [1:0]                        limit_hit
);
	import pfc_pkg::*;

	pfc_cfg_t cfg;

	logic                  valid_s1;
	logic [FLOW_BITS-1:0]  meas_s1;
	logic [FLOW_BITS-1:0]  targ_s1;
	logic                  clear_s1;

	logic                  out_valid_q;
	logic [DRIVE_BITS-1:0] drive_q;
	limit_t                limit_q;

	logic                  advance;
	logic                  load_s1;
	logic [DRIVE_BITS-1:0] core_drive;
	limit_t                core_limit;

	assign pready = 1'b1;

	pfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The input stage moves on whenever the result register is empty or being taken.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			meas_s1  <= measured_flow;
			targ_s1  <= target_flow;
			clear_s1 <= clear_history;
		end
	end

	pfc_core #(
		.FLOW_BITS      (FLOW_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.meas   (meas_s1),
		.targ   (targ_s1),
		.clear  (clear_s1),
		.cfg    (cfg),
		.drive  (core_drive),
		.limit  (core_limit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= core_drive;
			limit_q <= core_limit;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign limit_hit   = limit_q;

endmodule

`default_nettype wire

// ===== src/pfc_regs.sv =====
// APB register file holding the gains and output limits of the controller.
`default_nettype none

module pfc_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [pfc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [pfc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [pfc_pkg::APB_DATA_BITS-1:0]  prdata,
	output pfc_pkg::pfc_cfg_t                       cfg
);
	import pfc_pkg::*;

	pfc_cfg_t   cfg_q;
	reg_index_t idx;
	logic       wr_en;

	assign idx   = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= GAIN_P_RST;
			cfg_q.gain_i         <= GAIN_I_RST;
			cfg_q.gain_d         <= GAIN_D_RST;
			cfg_q.output_floor   <= OUTPUT_FLOOR_RST;
			cfg_q.output_ceiling <= OUTPUT_CEILING_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:         cfg_q.gain_p         <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_I:         cfg_q.gain_i         <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_D:         cfg_q.gain_d         <= pwdata[GAIN_BITS-1:0];
				REG_OUTPUT_FLOOR:   cfg_q.output_floor   <= pwdata[GAIN_BITS-1:0];
				REG_OUTPUT_CEILING: cfg_q.output_ceiling <= pwdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:         prdata = APB_DATA_BITS'(cfg_q.gain_p);
			REG_GAIN_I:         prdata = APB_DATA_BITS'(cfg_q.gain_i);
			REG_GAIN_D:         prdata = APB_DATA_BITS'(cfg_q.gain_d);
			REG_OUTPUT_FLOOR:   prdata = APB_DATA_BITS'(cfg_q.output_floor);
			REG_OUTPUT_CEILING: prdata = APB_DATA_BITS'(cfg_q.output_ceiling);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/pfc_core.sv =====
// One control step: error terms, three gain products, clamp and integral update.
`default_nettype none

module pfc_core #(
	parameter int FLOW_BITS      = pfc_pkg::FLOW_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pfc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire logic [FLOW_BITS-1:0]             meas,
	input  wire logic [FLOW_BITS-1:0]             targ,
	input  wire logic                             clear,
	input  wire pfc_pkg::pfc_cfg_t                cfg,
	output logic      [pfc_pkg::DRIVE_BITS-1:0]   drive,
	output pfc_pkg::limit_t                       limit
);
	import pfc_pkg::*;

	localparam int ERR_W  = FLOW_BITS + 1;
	localparam int PPD_W  = ERR_W + GAIN_BITS + 1;
	localparam int PI_W   = INTEGRAL_BITS + GAIN_BITS + 1;
	localparam int SUM_W  = ((PPD_W > PI_W) ? PPD_W : PI_W) + 2;
	localparam int ACC_W  = ((ERR_W > INTEGRAL_BITS) ? ERR_W : INTEGRAL_BITS) + 1;
	localparam int LIM_PAD = SUM_W - GAIN_BITS - GAIN_FRAC_BITS;

	logic signed [INTEGRAL_BITS-1:0] integral_q;
	logic        [FLOW_BITS-1:0]     prev_q;

	logic signed [INTEGRAL_BITS-1:0] integ_eff;
	logic        [FLOW_BITS-1:0]     prev_eff;
	logic signed [ERR_W-1:0]         err;
	logic signed [ERR_W-1:0]         deriv;
	logic signed [PPD_W-1:0]         prod_p;
	logic signed [PPD_W-1:0]         prod_d;
	logic signed [PI_W-1:0]          prod_i;
	logic signed [SUM_W-1:0]         sum;
	logic signed [SUM_W-1:0]         hi;
	logic signed [SUM_W-1:0]         lo;
	logic signed [ACC_W-1:0]         acc;
	logic signed [ACC_W-1:0]         int_max_x;
	logic signed [ACC_W-1:0]         int_min_x;
	logic signed [INTEGRAL_BITS-1:0] acc_sat;
	logic signed [INTEGRAL_BITS-1:0] integral_d;

	always_comb begin
		// Clearing acts before the step is computed.
		integ_eff = clear ? '0 : integral_q;
		prev_eff  = clear ? '0 : prev_q;

		err   = $signed({1'b0, targ}) - $signed({1'b0, meas});
		deriv = $signed({1'b0, prev_eff}) - $signed({1'b0, meas});

		prod_p = $signed({1'b0, cfg.gain_p}) * err;
		prod_i = $signed({1'b0, cfg.gain_i}) * integ_eff;
		prod_d = $signed({1'b0, cfg.gain_d}) * deriv;

		sum = $signed({{(SUM_W-PPD_W){prod_p[PPD_W-1]}}, prod_p})
			+ $signed({{(SUM_W-PI_W){prod_i[PI_W-1]}}, prod_i})
			+ $signed({{(SUM_W-PPD_W){prod_d[PPD_W-1]}}, prod_d});

		hi = $signed({{LIM_PAD{1'b0}}, cfg.output_ceiling, {GAIN_FRAC_BITS{1'b0}}});
		lo = $signed({{LIM_PAD{1'b0}}, cfg.output_floor, {GAIN_FRAC_BITS{1'b0}}});

		acc = $signed({{(ACC_W-INTEGRAL_BITS){integ_eff[INTEGRAL_BITS-1]}}, integ_eff})
			+ $signed({{(ACC_W-ERR_W){err[ERR_W-1]}}, err});
		int_max_x = $signed({{(ACC_W-INTEGRAL_BITS+1){1'b0}}, {(INTEGRAL_BITS-1){1'b1}}});
		int_min_x = $signed({{(ACC_W-INTEGRAL_BITS+1){1'b1}}, {(INTEGRAL_BITS-1){1'b0}}});
		if (acc > int_max_x) begin
			acc_sat = int_max_x[INTEGRAL_BITS-1:0];
		end else if (acc < int_min_x) begin
			acc_sat = int_min_x[INTEGRAL_BITS-1:0];
		end else begin
			acc_sat = acc[INTEGRAL_BITS-1:0];
		end

		// High is tested first; a floor above the ceiling clamps sums below it low.
		// The integral only absorbs the error when the output is within range.
		if (sum >= hi) begin
			drive      = cfg.output_ceiling;
			limit      = LIMIT_HIGH;
			integral_d = integ_eff;
		end else if (sum <= lo) begin
			drive      = cfg.output_floor;
			limit      = LIMIT_LOW;
			integral_d = integ_eff;
		end else begin
			drive      = sum[GAIN_FRAC_BITS +: DRIVE_BITS];
			limit      = LIMIT_NONE;
			integral_d = acc_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_q     <= '0;
		end else if (step) begin
			integral_q <= integral_d;
			prev_q     <= meas;
		end
	end

endmodule

`default_nettype wire

// ===== src/pfc_checker.sv =====
// Port-level checks for the PID flow controller, bound to the top level.
`default_nettype none

module pfc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [pfc_pkg::DRIVE_BITS-1:0] drive_value,
	input wire logic [1:0]                     limit_hit
);
	import pfc_pkg::*;

	// Only a legal limit code is ever presented with a result.
	a_limit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (limit_hit == LIMIT_NONE || limit_hit == LIMIT_HIGH ||
			limit_hit == LIMIT_LOW))
		else $error("illegal limit code on result");

	// The input side is only held off by a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without downstream stall");

	// An item accepted while the output is empty reaches the output as a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
		else $error("result missing after accepted item");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(drive_value) && $stable(limit_hit)))
		else $error("stalled result changed");

endmodule

bind pid_flow_controller pfc_checker u_pfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.drive_value   (drive_value),
	.limit_hit     (limit_hit)
);

`default_nettype wire

// ===== tb/pid_flow_controller_check.sv =====
`timescale 1ns / 100ps
// Checker for the PID flow controller: tracks its registers, predicts each drive value and compares.
module pid_flow_controller_check (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       psel,
	input  wire logic                                       penable,
	input  wire logic                                       pwrite,
	input  wire logic                                       pready,
	input  wire logic [pfc_pkg::APB_ADDR_BITS-1:0]          paddr,
	input  wire logic [pfc_pkg::APB_DATA_BITS-1:0]          pwdata,
	input  wire logic                                       in_valid,
	input  wire logic                                       in_stall,
	input  wire logic [pfc_pkg::FLOW_BITS_DEF-1:0]          measured_flow,
	input  wire logic [pfc_pkg::FLOW_BITS_DEF-1:0]          target_flow,
	input  wire logic                                       clear_history,
	input  wire logic                                       out_valid,
	input  wire logic                                       out_stall,
	input  wire logic [pfc_pkg::DRIVE_BITS-1:0]             drive_value,
	input  wire logic [1:0]                                 limit_hit,
	output int                                              fail_count,
	output int                                              pending
);
	import pfc_pkg::*;

	localparam longint INTEGRAL_MAX = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
	localparam longint INTEGRAL_MIN = -(longint'(1) <<< (INTEGRAL_BITS - 1));

	typedef struct {
		logic [DRIVE_BITS-1:0] drive;
		limit_t                limit;
	} drive_result_t;

	drive_result_t drive_q[$];
	drive_result_t want;

	longint kp, ki, kd, floor_val, ceil_val;
	longint integral_acc, prev_meas;

	function automatic drive_result_t control_step(input logic [FLOW_BITS_DEF-1:0] meas,
			input logic [FLOW_BITS_DEF-1:0] targ, input logic clr);
		longint m, t, err, deriv, sum, hi, lo;
		drive_result_t r;
		m = meas;
		t = targ;
		if (clr) begin
			integral_acc = 0;
			prev_meas = 0;
		end
		err = t - m;
		deriv = prev_meas - m;
		prev_meas = m;
		// The integral used here is the one left by the previous step.
		sum = kp * err + ki * integral_acc + kd * deriv;
		hi = ceil_val << GAIN_FRAC_BITS_DEF;
		lo = floor_val << GAIN_FRAC_BITS_DEF;
		if (sum >= hi) begin
			r.drive = ceil_val[DRIVE_BITS-1:0];
			r.limit = LIMIT_HIGH;
		end else if (sum <= lo) begin
			r.drive = floor_val[DRIVE_BITS-1:0];
			r.limit = LIMIT_LOW;
		end else begin
			r.drive = sum[GAIN_FRAC_BITS_DEF +: DRIVE_BITS];
			r.limit = LIMIT_NONE;
			integral_acc = integral_acc + err;
			if (integral_acc > INTEGRAL_MAX) integral_acc = INTEGRAL_MAX;
			if (integral_acc < INTEGRAL_MIN) integral_acc = INTEGRAL_MIN;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = GAIN_P_RST;
			ki = GAIN_I_RST;
			kd = GAIN_D_RST;
			floor_val = OUTPUT_FLOOR_RST;
			ceil_val = OUTPUT_CEILING_RST;
			integral_acc = 0;
			prev_meas = 0;
			drive_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_BITS-1:2])
					REG_GAIN_P:         kp = pwdata[GAIN_BITS-1:0];
					REG_GAIN_I:         ki = pwdata[GAIN_BITS-1:0];
					REG_GAIN_D:         kd = pwdata[GAIN_BITS-1:0];
					REG_OUTPUT_FLOOR:   floor_val = pwdata[GAIN_BITS-1:0];
					REG_OUTPUT_CEILING: ceil_val = pwdata[GAIN_BITS-1:0];
					default: ;
				endcase
			end
			// Results leave before new items are predicted, so a result is never
			// matched against the item accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected, drive_value %0d limit_hit %0d",
						$time, drive_value, limit_hit);
				end else begin
					want = drive_q.pop_front();
					if (drive_value !== want.drive) begin
						fail_count++;
						$display("%0t: drive_value expected %0d, actual %0d",
							$time, want.drive, drive_value);
					end
					if (limit_hit !== want.limit) begin
						fail_count++;
						$display("%0t: limit_hit expected %0d, actual %0d",
							$time, want.limit, limit_hit);
					end
				end
			end
			if (in_valid && !in_stall)
				drive_q.push_back(control_step(measured_flow, target_flow, clear_history));
			pending = drive_q.size();
		end
	end

endmodule

// ===== tb/pid_flow_controller_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the PID flow controller: clock, reset, register writes, items and verdict.
module pid_flow_controller_test;
	import pfc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 135;
	localparam int HOLD_CYCLES = 60;
	localparam logic [REG_INDEX_BITS-1:0] REG_SPARE = 3'd5;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0]     paddr = '0;
	logic [APB_DATA_BITS-1:0]     pwdata = '0;
	logic [APB_DATA_BITS-1:0]     prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [FLOW_BITS_DEF-1:0]     measured_flow = '0;
	logic [FLOW_BITS_DEF-1:0]     target_flow = '0;
	logic                         clear_history = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [DRIVE_BITS-1:0]        drive_value;
	logic [1:0]                   limit_hit;

	int                           fail_count;
	int                           pending;
	int                           idle_pct = 0;
	int                           stall_pct = 0;
	int                           cycle_count;
	bit                           hold_request = 1'b0;
	logic [FLOW_BITS_DEF-1:0]     last_meas = '0;

	always #2 clk = ~clk;

	pid_flow_controller u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.measured_flow (measured_flow),
		.target_flow   (target_flow),
		.clear_history (clear_history),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive_value   (drive_value),
		.limit_hit     (limit_hit)
	);

	pid_flow_controller_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.measured_flow (measured_flow),
		.target_flow   (target_flow),
		.clear_history (clear_history),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive_value   (drive_value),
		.limit_hit     (limit_hit),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Receiver: random stalls, or a long hold-off counted here when one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[pid_flow_controller] ERROR");
		$finish;
	end

	task automatic reg_write(input logic [REG_INDEX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] value);
		logic [APB_DATA_BITS-1:0] junk;
		junk = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// Upper data bits are noise; the registers keep only the low half.
		pwdata <= {junk[APB_DATA_BITS-1:GAIN_BITS], value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gains(input logic [GAIN_BITS-1:0] p, input logic [GAIN_BITS-1:0] i,
			input logic [GAIN_BITS-1:0] d, input logic [GAIN_BITS-1:0] lo,
			input logic [GAIN_BITS-1:0] hi);
		reg_write(REG_GAIN_P, p);
		reg_write(REG_GAIN_I, i);
		reg_write(REG_GAIN_D, d);
		reg_write(REG_OUTPUT_FLOOR, lo);
		reg_write(REG_OUTPUT_CEILING, hi);
	endtask

	task automatic send_item(input logic [FLOW_BITS_DEF-1:0] meas,
			input logic [FLOW_BITS_DEF-1:0] targ, input logic clr);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		measured_flow <= meas;
		target_flow <= targ;
		clear_history <= clr;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_item();
		logic [FLOW_BITS_DEF-1:0] meas, targ, nudge, offset;
		int pick;
		pick = $urandom_range(99);
		meas = FLOW_BITS_DEF'($urandom);
		targ = FLOW_BITS_DEF'($urandom);
		nudge = FLOW_BITS_DEF'($urandom_range(64));
		offset = FLOW_BITS_DEF'($urandom_range(400));
		if (pick < 50) begin
			// Small wander around the set point keeps the output mostly unclamped,
			// so the integral actually builds up.
			meas = last_meas + nudge - 16'd32;
			targ = meas + offset - 16'd200;
		end else if (pick < 60) begin
			meas = $urandom_range(1) ? '1 : '0;
		end
		last_meas = meas;
		send_item(meas, targ, $urandom_range(99) < 4);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under the reset settings.
		send_item(16'd0, 16'd0, 1'b1);
		send_item(16'd0, 16'hFFFF, 1'b0);
		send_item(16'hFFFF, 16'd0, 1'b0);
		send_item(16'hFFFF, 16'hFFFF, 1'b0);
		send_item(16'd1000, 16'd1050, 1'b1);
		send_item(16'd1000, 16'd1050, 1'b0);
		send_item(16'd1000, 16'd1060, 1'b0);
		send_item(16'd1000, 16'd1060, 1'b0);
		send_item(16'd1010, 16'd1000, 1'b0);
		send_item(16'd32768, 16'd32767, 1'b0);
		send_item(16'd1, 16'd0, 1'b0);
		send_item(16'd0, 16'd1, 1'b1);
		wait_drained();

		// Floor set above the ceiling: the high test wins.
		set_gains(16'd3277, 16'd2048, 16'd82, 16'd200, 16'd50);
		send_item(16'd500, 16'd600, 1'b1);
		send_item(16'd600, 16'd500, 1'b0);
		send_item(16'd0, 16'hFFFF, 1'b0);
		wait_drained();

		// A write past the last register must change nothing.
		reg_write(REG_SPARE, 16'h1234);
		send_item(16'd550, 16'd560, 1'b0);
		wait_drained();

		set_gains('1, '1, '1, '0, '1);
		send_item(16'd0, 16'hFFFF, 1'b1);
		send_item(16'hFFFF, 16'd0, 1'b0);
		send_item(16'h7FFF, 16'h8000, 1'b0);
		wait_drained();

		for (int k = 0; k < 8; k++) begin
			idle_pct = 0;
			stall_pct = 0;
			wait_drained();
			case (k)
				0: set_gains(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, OUTPUT_FLOOR_RST,
					OUTPUT_CEILING_RST);
				1: set_gains('1, '1, '1, '0, '1);
				2: set_gains('0, '0, '0, '1, '1);
				6: set_gains(GAIN_BITS'($urandom_range(8192)), GAIN_BITS'($urandom_range(1024)),
					GAIN_BITS'($urandom_range(4096)), GAIN_BITS'($urandom_range(20000, 2000)),
					GAIN_BITS'($urandom_range(1500)));
				default: begin
					logic [GAIN_BITS-1:0] lo;
					lo = GAIN_BITS'($urandom_range(500));
					set_gains(GAIN_BITS'($urandom_range(8192)), GAIN_BITS'($urandom_range(1024)),
						GAIN_BITS'($urandom_range(4096)), lo,
						lo + GAIN_BITS'($urandom_range(20000)));
				end
			endcase
			idle_pct = (k % 4 == 1) ? 76 : (k % 4 == 3) ? 14 : 0;
			stall_pct = (k % 4 == 2) ? 76 : (k % 4 == 3) ? 14 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (k == 4 && n == 60) hold_request = 1'b1;
				if (k == 5 && n == 60) wait_drained();
				random_item();
			end
		end
		idle_pct = 0;
		stall_pct = 0;
		wait_drained();

		if (fail_count == 0 && pending == 0) begin
			$display("[pid_flow_controller] OK");
		end else begin
			$display("[pid_flow_controller] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pfc_pkg.sv
src/pfc_regs.sv
src/pfc_core.sv
src/pid_flow_controller.sv
src/pfc_checker.sv
tb/pid_flow_controller_check.sv
tb/pid_flow_controller_test.sv
